// ===== rtl/msra_pkg.sv =====
// Shared types, codes and sizing constants for the slot region allocator.
package msra_pkg;

  // Table and hole geometry
  localparam int NUM_SLOTS      = 8;
  localparam int PAGE_BYTES     = 4096;
  localparam int MAX_HOLE_PAGES = 65535;
  localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
  localparam int IDX_W          = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PG_W           = $clog2(MAX_HOLE_PAGES + 1);
  // Wide enough for any region end and for candidate start plus rounded size
  localparam int SPAN_W         = ((PG_W + PAGE_SHIFT > 29) ? PG_W + PAGE_SHIFT : 29) + 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 4;
  localparam int UUID_W   = 64;
  localparam int SIZE_W   = 28;
  localparam int MASK_W   = 8;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 3;
  localparam int CFG_W    = 16;

  localparam logic [SLOT_W-1:0] ANY_SLOT = SLOT_W'(8);

  // Operation codes
  localparam logic [OP_W-1:0] OP_SAVE = 2'd0;
  localparam logic [OP_W-1:0] OP_WIPE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BADSLOT = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NODATA  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ALREADY = 3'd3;
  localparam logic [STATUS_W-1:0] STS_KEYREJ  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NOSPACE = 3'd5;
  localparam logic [STATUS_W-1:0] STS_TOOBIG  = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [UUID_W-1:0] uuid_high;
    logic [UUID_W-1:0] uuid_low;
    logic              match_uuid;
    logic [SIZE_W-1:0] data_size;
    logic              check_size;
    logic [MASK_W-1:0] keyslot_inactive_mask;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   slot_used;
    logic [SIZE_W-1:0]   region_offset;
    logic [SIZE_W-1:0]   region_length;
    logic [UUID_W-1:0]   stored_uuid_high;
    logic [UUID_W-1:0]   stored_uuid_low;
  } out_item_t;

  // Candidate region travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic              busy;
    logic [SPAN_W-1:0] start;
    logic [SPAN_W-1:0] stop;
  } probe_t;

  // Contents written into one slot cell
  typedef struct packed {
    logic [UUID_W-1:0] id_high;
    logic [UUID_W-1:0] id_low;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] length;
  } slot_wr_t;

  // Contents read back from one slot cell
  typedef struct packed {
    logic              occupied;
    logic [UUID_W-1:0] id_high;
    logic [UUID_W-1:0] id_low;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] length;
  } slot_rd_t;

endpackage

// ===== rtl/msra_slot_cell.sv =====
// One slot of the table plus one stage of the candidate overlap chain.
module msra_slot_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              kill_i,
  input  logic              wr_en_i,
  input  msra_pkg::slot_wr_t wr_i,
  input  msra_pkg::probe_t  probe_i,
  output msra_pkg::probe_t  probe_o,
  output msra_pkg::slot_rd_t rd_o
);
  import msra_pkg::*;

  slot_wr_t          store_r;
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic              occupied;
  logic [SPAN_W-1:0] slot_start;
  logic [SPAN_W-1:0] slot_stop;
  logic              hit;

  // Hold slot contents; reset empties the slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
    end else if (wr_en_i) begin
      store_r <= wr_i;
    end
  end

  // Test the candidate against this slot's half-open interval
  always_comb begin
    occupied   = |{store_r.id_high, store_r.id_low};
    slot_start = SPAN_W'(store_r.offset);
    slot_stop  = SPAN_W'(store_r.offset) + SPAN_W'(store_r.length);
    hit        = occupied && (probe_i.start < slot_stop) && (slot_start < probe_i.stop);
    probe_nxt       = probe_i;
    probe_nxt.busy  = probe_i.busy | hit;
    probe_nxt.valid = probe_i.valid & ~kill_i;
  end

  // Advance the candidate to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_o = probe_r;

  always_comb begin
    rd_o.occupied = occupied;
    rd_o.id_high  = store_r.id_high;
    rd_o.id_low   = store_r.id_low;
    rd_o.offset   = store_r.offset;
    rd_o.length   = store_r.length;
  end

endmodule

// ===== rtl/metadata_slot_region_allocator_unit.sv =====
// Top level of the slot region allocator: control, result register and cell chain.
//
// Usage: drive start with an item while busy is low; the item is taken on that
// edge and busy rises. Wipe, load and every request rejected up front produce
// their result from the evaluation state via the result register. A save runs
// a first-fit search: one candidate page offset enters a chain of NUM_SLOTS
// slot cells per cycle, each cell marking the candidate if it overlaps its
// slot, so the first candidate that leaves the chain unmarked is the lowest
// free fit, and a save that finds no fit reports no space. Each result
// appears on out_item for exactly one cycle with out_valid high and cannot be
// held off; the next item may be started in that same cycle. hole_pages is
// written through cfg_valid/cfg_data (cfg_ready is always high) and must only
// change while busy is low.
module metadata_slot_region_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  msra_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output msra_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msra_pkg::CFG_W-1:0]    cfg_data
);
  import msra_pkg::*;

  state_t              state_r, state_nxt;
  in_item_t            item_r;
  logic [CFG_W-1:0]    hole_pages_r;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    sel_r, sel_nxt;
  logic [PG_W-1:0]     cand_r, cand_nxt;
  logic [SPAN_W-1:0]   rsize_r, rsize_nxt;

  probe_t              chain [NUM_SLOTS+1];
  slot_rd_t            cell_rd [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] wr_en;
  logic [NUM_SLOTS-1:0] tok_valid;
  slot_wr_t            wr_data;

  // Evaluation of the latched item
  logic [NUM_SLOTS-1:0] ext_mask;
  logic                any_found;
  logic [IDX_W-1:0]    any_idx;
  logic                slot_in_range;
  logic [IDX_W-1:0]    eval_idx;
  logic [STATUS_W-1:0] eval_status;
  logic                eval_search;
  slot_rd_t            rd;
  logic [SPAN_W-1:0]   rsize_calc;

  // Search control
  logic [PG_W-1:0]     pages_w;
  logic [SPAN_W-1:0]   hole_w;
  logic [SPAN_W-1:0]   cand_start;
  logic [SPAN_W-1:0]   cand_stop;
  logic                issue_ok;
  logic                issue;
  logic                fit_w;
  logic                nospace_w;
  probe_t              exit_probe;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_pages_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      hole_pages_r <= cfg_data;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
  end

  // Slot cell chain
  assign chain[0].valid = issue;
  assign chain[0].busy  = 1'b0;
  assign chain[0].start = cand_start;
  assign chain[0].stop  = cand_stop;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    msra_slot_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .kill_i  (fit_w),
      .wr_en_i (wr_en[g]),
      .wr_i    (wr_data),
      .probe_i (chain[g]),
      .probe_o (chain[g+1]),
      .rd_o    (cell_rd[g])
    );
    assign tok_valid[g] = chain[g+1].valid;
  end

  assign exit_probe = chain[NUM_SLOTS];

  // Pick the lowest empty slot whose key slot is inactive
  always_comb begin
    ext_mask  = NUM_SLOTS'(item_r.keyslot_inactive_mask);
    any_found = 1'b0;
    any_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (ext_mask[i] && !cell_rd[i].occupied) begin
        any_found = 1'b1;
        any_idx   = IDX_W'(i);
      end
    end
  end

  // Decode the item against the table
  always_comb begin
    slot_in_range = {2'b00, item_r.slot} < 6'(NUM_SLOTS);
    eval_idx      = IDX_W'(item_r.slot);
    eval_status   = STS_OK;
    eval_search   = 1'b0;
    if (item_r.operation == OP_SAVE && item_r.slot == ANY_SLOT) begin
      eval_idx = any_idx;
    end
    rd = cell_rd[eval_idx];
    case (item_r.operation)
      OP_SAVE: begin
        if (item_r.uuid_high == '0 && item_r.uuid_low == '0) begin
          eval_status = STS_KEYREJ;
        end else if (item_r.slot == ANY_SLOT && !any_found) begin
          eval_status = STS_BADSLOT;
        end else if (item_r.slot != ANY_SLOT && !slot_in_range) begin
          eval_status = STS_BADSLOT;
        end else if (rd.occupied) begin
          eval_status = STS_ALREADY;
        end else begin
          eval_search = 1'b1;
        end
      end
      OP_WIPE: begin
        if (!slot_in_range) begin
          eval_status = STS_BADSLOT;
        end else if (!rd.occupied) begin
          eval_status = STS_ALREADY;
        end else if (item_r.match_uuid &&
                     (item_r.uuid_high != rd.id_high || item_r.uuid_low != rd.id_low)) begin
          eval_status = STS_KEYREJ;
        end
      end
      OP_LOAD: begin
        if (!slot_in_range) begin
          eval_status = STS_BADSLOT;
        end else if (!rd.occupied) begin
          eval_status = STS_NODATA;
        end else if (item_r.check_size && item_r.data_size < rd.length) begin
          eval_status = STS_TOOBIG;
        end
      end
      default: begin
        eval_status = STS_BADSLOT;
      end
    endcase
  end

  // Round the region up to whole pages and bound the hole
  always_comb begin
    rsize_calc = ((SPAN_W'(item_r.data_size) + SPAN_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT)
                 << PAGE_SHIFT;
    if (32'(hole_pages_r) > 32'(MAX_HOLE_PAGES)) begin
      pages_w = PG_W'(MAX_HOLE_PAGES);
    end else begin
      pages_w = PG_W'(hole_pages_r);
    end
    hole_w     = SPAN_W'(pages_w) << PAGE_SHIFT;
    cand_start = SPAN_W'(cand_r) << PAGE_SHIFT;
    cand_stop  = cand_start + rsize_r;
    issue_ok   = (cand_r < pages_w) && (cand_stop <= hole_w);
    fit_w      = (state_r == S_SEARCH) && exit_probe.valid && !exit_probe.busy;
    nospace_w  = (state_r == S_SEARCH) && !issue_ok && !(|tok_valid);
    issue      = (state_r == S_SEARCH) && issue_ok && !fit_w;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = eval_search ? S_SEARCH : S_IDLE;
      end
      S_SEARCH: begin
        if (fit_w || nospace_w) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Results, table writes and search counters
  always_comb begin
    res_nxt       = '0;
    out_valid_nxt = 1'b0;
    wr_en         = '0;
    wr_data       = '0;
    sel_nxt       = sel_r;
    cand_nxt      = cand_r;
    rsize_nxt     = rsize_r;
    case (state_r)
      S_EVAL: begin
        sel_nxt   = eval_idx;
        cand_nxt  = PG_W'(1);
        rsize_nxt = rsize_calc;
        if (!eval_search) begin
          out_valid_nxt  = 1'b1;
          res_nxt.status = eval_status;
          if (eval_status == STS_OK) begin
            res_nxt.slot_used     = USED_W'(eval_idx);
            res_nxt.region_offset = rd.offset;
            res_nxt.region_length = rd.length;
            if (item_r.operation == OP_WIPE) begin
              wr_en[eval_idx] = 1'b1;
            end else begin
              res_nxt.stored_uuid_high = rd.id_high;
              res_nxt.stored_uuid_low  = rd.id_low;
            end
          end
        end
      end
      S_SEARCH: begin
        if (issue) cand_nxt = cand_r + PG_W'(1);
        if (fit_w) begin
          wr_en[sel_r]          = 1'b1;
          wr_data.id_high       = item_r.uuid_high;
          wr_data.id_low        = item_r.uuid_low;
          wr_data.offset        = exit_probe.start[SIZE_W-1:0];
          wr_data.length        = item_r.data_size;
          out_valid_nxt         = 1'b1;
          res_nxt.status        = STS_OK;
          res_nxt.slot_used     = USED_W'(sel_r);
          res_nxt.region_offset = exit_probe.start[SIZE_W-1:0];
          res_nxt.region_length = item_r.data_size;
        end else if (nospace_w) begin
          out_valid_nxt  = 1'b1;
          res_nxt.status = STS_NOSPACE;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    sel_r   <= sel_nxt;
    cand_r  <= cand_nxt;
    rsize_r <= rsize_nxt;
  end

  // A result only shows once control is back in idle
  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe outside idle");

  // Every item starts with an empty candidate chain
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> !(|tok_valid))
    else $error("stale candidate in chain at item start");

  // At most one slot written per cycle
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_en))
    else $error("multiple slot writes");

  // A found region never starts in the header page
  a_fit_past_header: assert property (@(posedge clk) disable iff (!rst_n)
    fit_w |-> exit_probe.start >= SPAN_W'(PAGE_BYTES))
    else $error("region placed in header page");

endmodule

// ===== sim/metadata_slot_region_allocator_unit_test.sv =====
// Self-checking testbench for the slot region allocator: directed and random save/wipe/load items.
module metadata_slot_region_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msra_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = NUM_SLOTS + 4;
  localparam int unsigned MAX_PRINTS = 200;

  // Mirror of the slot table: predicts one result per accepted item
  class allocator_predictor;
    bit [CFG_W-1:0]  hole_pages;
    bit [UUID_W-1:0] id_high [NUM_SLOTS];
    bit [UUID_W-1:0] id_low [NUM_SLOTS];
    bit [SIZE_W-1:0] region_start [NUM_SLOTS];
    bit [SIZE_W-1:0] region_len [NUM_SLOTS];
    out_item_t       expected_results [$];
    int unsigned     fail_count;

    function new();
      hole_pages = '0;
      fail_count = 0;
      foreach (id_high[i]) begin
        id_high[i] = '0;
        id_low[i] = '0;
        region_start[i] = '0;
        region_len[i] = '0;
      end
    endfunction

    function bit is_empty(int s);
      return id_high[s] == '0 && id_low[s] == '0;
    endfunction

    // Half-open interval test against every occupied slot
    function bit overlaps(bit [63:0] lo, bit [63:0] hi);
      bit [63:0] s;
      bit [63:0] e;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        s = 64'(region_start[i]);
        e = s + 64'(region_len[i]);
        if (!is_empty(i) && lo < e && s < hi) return 1'b1;
      end
      return 1'b0;
    endfunction

    // First-fit page-aligned search; zero means nothing fits
    function bit [63:0] find_region(bit [63:0] size);
      bit [63:0] pages;
      bit [63:0] hole;
      bit [63:0] rsize;
      bit [63:0] off;
      pages = 64'(hole_pages);
      if (pages > 64'(MAX_HOLE_PAGES)) pages = 64'(MAX_HOLE_PAGES);
      hole = pages * 64'(PAGE_BYTES);
      rsize = ((size + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES)) * 64'(PAGE_BYTES);
      off = 64'(PAGE_BYTES);
      while (off < hole && off + rsize <= hole) begin
        if (!overlaps(off, off + rsize)) return off;
        off = off + 64'(PAGE_BYTES);
      end
      return 64'd0;
    endfunction

    function void set_hole_pages(bit [CFG_W-1:0] pages);
      hole_pages = pages;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted item to the table and queue its result
    function void note_request(in_item_t it);
      out_item_t r;
      bit        found;
      int        s;
      bit [63:0] off;
      r = '0;
      r.status = STS_OK;
      s = 0;
      found = 1'b0;
      case (it.operation)
        OP_SAVE: begin
          if (it.uuid_high == '0 && it.uuid_low == '0) begin
            r.status = STS_KEYREJ;
          end else begin
            if (it.slot == ANY_SLOT) begin
              for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!found && it.keyslot_inactive_mask[i] && is_empty(i)) begin
                  s = i;
                  found = 1'b1;
                end
              end
            end else if (it.slot < NUM_SLOTS) begin
              s = int'(it.slot);
              found = 1'b1;
            end
            if (!found) begin
              r.status = STS_BADSLOT;
            end else if (!is_empty(s)) begin
              r.status = STS_ALREADY;
            end else begin
              off = find_region(64'(it.data_size));
              if (off < 64'(PAGE_BYTES)) begin
                r.status = STS_NOSPACE;
              end else begin
                id_high[s] = it.uuid_high;
                id_low[s] = it.uuid_low;
                region_start[s] = off[SIZE_W-1:0];
                region_len[s] = it.data_size;
                r.slot_used = USED_W'(s);
                r.region_offset = off[SIZE_W-1:0];
                r.region_length = it.data_size;
              end
            end
          end
        end
        OP_WIPE, OP_LOAD: begin
          if (it.slot >= NUM_SLOTS) begin
            r.status = STS_BADSLOT;
          end else begin
            s = int'(it.slot);
            if (it.operation == OP_WIPE) begin
              if (is_empty(s)) begin
                r.status = STS_ALREADY;
              end else if (it.match_uuid &&
                           (it.uuid_high != id_high[s] || it.uuid_low != id_low[s])) begin
                r.status = STS_KEYREJ;
              end else begin
                r.slot_used = USED_W'(s);
                r.region_offset = region_start[s];
                r.region_length = region_len[s];
                id_high[s] = '0;
                id_low[s] = '0;
                region_start[s] = '0;
                region_len[s] = '0;
              end
            end else begin
              if (is_empty(s)) begin
                r.status = STS_NODATA;
              end else if (it.check_size && it.data_size < region_len[s]) begin
                r.status = STS_TOOBIG;
              end else begin
                r.slot_used = USED_W'(s);
                r.region_offset = region_start[s];
                r.region_length = region_len[s];
                r.stored_uuid_high = id_high[s];
                r.stored_uuid_low = id_low[s];
              end
            end
          end
        end
        default: r.status = STS_BADSLOT;
      endcase
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      fail_count++;
      if (fail_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare one result against the oldest pending one
    task check_response(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending");
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 64'(got.status), 64'(want.status));
      compare_field("slot_used", 64'(got.slot_used), 64'(want.slot_used));
      compare_field("region_offset", 64'(got.region_offset), 64'(want.region_offset));
      compare_field("region_length", 64'(got.region_length), 64'(want.region_length));
      compare_field("stored_uuid_high", got.stored_uuid_high, want.stored_uuid_high);
      compare_field("stored_uuid_low", got.stored_uuid_low, want.stored_uuid_low);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;

  allocator_predictor board = new();

  metadata_slot_region_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Observe accepted items and results at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start && !busy) board.note_request(in_item);
      if (out_valid) board.check_response(out_item);
    end
  end

  // Hold one item until the block takes it; return at the next falling edge
  task send_request(in_item_t it);
    in_item = it;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start and wait until every pending result has come back
  task wait_drain();
    start = 1'b0;
    while (board.pending() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_hole_pages(logic [CFG_W-1:0] pages);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data = pages;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_hole_pages(pages);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task directed(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot, logic [UUID_W-1:0] hi,
                logic [UUID_W-1:0] lo, logic match, logic [SIZE_W-1:0] size, logic chk,
                logic [MASK_W-1:0] mask);
    in_item_t it;
    it.operation = op;
    it.slot = slot;
    it.uuid_high = hi;
    it.uuid_low = lo;
    it.match_uuid = match;
    it.data_size = size;
    it.check_size = chk;
    it.keyslot_inactive_mask = mask;
    send_request(it);
  endtask

  // Build one random item, mostly well formed, biased toward the current table
  function automatic in_item_t make_request(int unsigned cap_bytes, bit wide_sizes);
    in_item_t    it;
    int unsigned r;
    int unsigned k;
    bit [SIZE_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 45) it.operation = OP_SAVE;
    else if (r < 70) it.operation = OP_WIPE;
    else if (r < 95) it.operation = OP_LOAD;
    else it.operation = OP_UNUSED;

    r = $urandom_range(0, 99);
    if (r < 75) it.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    else if (r < 88) it.slot = ANY_SLOT;
    else it.slot = SLOT_W'($urandom_range(9, 15));

    it.uuid_high = {$urandom, $urandom};
    it.uuid_low = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    if (r == 0) begin
      it.uuid_high = '0;
      it.uuid_low = '0;
    end else if (r == 1) begin
      it.uuid_high = '0;
    end else if (r == 2) begin
      it.uuid_low = '0;
    end

    // Reuse the stored identifier so matched wipes get through
    if (it.operation == OP_WIPE && it.slot < NUM_SLOTS && $urandom_range(0, 9) < 6) begin
      it.uuid_high = board.id_high[it.slot[IDX_W-1:0]];
      it.uuid_low = board.id_low[it.slot[IDX_W-1:0]];
      if ($urandom_range(0, 3) == 0)
        it.uuid_low = it.uuid_low ^ (64'd1 << $urandom_range(0, 63));
    end

    it.match_uuid = 1'($urandom_range(0, 1));
    it.check_size = 1'($urandom_range(0, 1));
    it.keyslot_inactive_mask = ($urandom_range(0, 3) == 0) ? '1 : MASK_W'($urandom);

    r = $urandom_range(0, 99);
    if (r < 65) begin
      it.data_size = SIZE_W'($urandom_range(0, cap_bytes));
    end else if (r < 80) begin
      k = $urandom_range(0, cap_bytes / PAGE_BYTES) * PAGE_BYTES;
      if (k > 0 && $urandom_range(0, 1) == 0) k = k - 1;
      else k = k + $urandom_range(0, 1);
      it.data_size = SIZE_W'(k);
    end else if (r < 90 && wide_sizes) begin
      it.data_size = SIZE_W'($urandom);
    end else begin
      len = board.region_len[it.slot[IDX_W-1:0]];
      if (len > 0 && $urandom_range(0, 2) == 0) it.data_size = len - 1'b1;
      else it.data_size = len + SIZE_W'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // One configuration setting followed by random bursts
  task run_phase(logic [CFG_W-1:0] pages, int count);
    int unsigned cap;
    bit          wide;
    int          left;
    int          burst;
    write_hole_pages(pages);
    wide = (pages <= 4096);
    cap = wide ? (int'(pages) + 2) * PAGE_BYTES : 64 * PAGE_BYTES;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_request(make_request(cap, wide));
        burst--;
        left--;
      end
      // Usually pause between bursts; sometimes wait for the table to settle
      if ($urandom_range(0, 19) == 0) begin
        wait_drain();
      end else if ($urandom_range(0, 3) != 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  localparam logic [UUID_W-1:0] ID_A = 64'h0123_4567_89AB_CDEF;
  localparam logic [UUID_W-1:0] ID_B = 64'hFEDC_BA98_7654_3210;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Empty hole: nothing can be placed
    write_hole_pages(16'd0);
    directed(OP_SAVE, 4'd0, ID_A, ID_B, 1'b0, 28'd1, 1'b0, 8'h00);

    // Small hole: basic placement and every error path
    write_hole_pages(16'd6);
    directed(OP_SAVE, 4'd0, 64'd0, 64'd0, 1'b0, 28'd4096, 1'b0, 8'hFF);
    directed(OP_SAVE, 4'd0, ID_A, 64'd1, 1'b0, 28'd0, 1'b0, 8'h00);
    directed(OP_SAVE, 4'd1, ID_B, ID_A, 1'b0, 28'd4097, 1'b0, 8'h00);
    directed(OP_SAVE, 4'd0, ID_B, ID_B, 1'b0, 28'd16, 1'b0, 8'h00);
    directed(OP_SAVE, ANY_SLOT, ID_A, ID_A, 1'b0, 28'd4096, 1'b0, 8'h00);
    directed(OP_SAVE, ANY_SLOT, ID_A, ID_A, 1'b0, 28'd4096, 1'b0, 8'hFF);
    directed(OP_SAVE, 4'd9, ID_A, ID_A, 1'b0, 28'd16, 1'b0, 8'hFF);
    directed(OP_SAVE, 4'd15, ID_A, ID_A, 1'b0, 28'd16, 1'b0, 8'hFF);
    directed(OP_SAVE, 4'd3, ID_A, ID_B, 1'b0, SIZE_MAX, 1'b0, 8'h00);
    directed(OP_SAVE, 4'd3, ID_A, ID_B, 1'b0, 28'd12288, 1'b0, 8'h00);
    directed(OP_LOAD, 4'd1, 64'd0, 64'd0, 1'b0, 28'd4096, 1'b1, 8'h00);
    directed(OP_LOAD, 4'd1, 64'd0, 64'd0, 1'b0, 28'd4097, 1'b1, 8'h00);
    directed(OP_LOAD, 4'd1, 64'd0, 64'd0, 1'b0, 28'd0, 1'b0, 8'h00);
    directed(OP_LOAD, 4'd5, 64'd0, 64'd0, 1'b0, 28'd0, 1'b0, 8'h00);
    directed(OP_LOAD, ANY_SLOT, 64'd0, 64'd0, 1'b0, 28'd0, 1'b0, 8'hFF);
    directed(OP_WIPE, 4'd1, ID_B, ID_B, 1'b1, 28'd0, 1'b0, 8'h00);
    directed(OP_WIPE, 4'd1, ID_B, ID_A, 1'b1, 28'd0, 1'b0, 8'h00);
    directed(OP_WIPE, 4'd1, ID_B, ID_A, 1'b1, 28'd0, 1'b0, 8'h00);
    directed(OP_WIPE, ANY_SLOT, ID_A, ID_A, 1'b0, 28'd0, 1'b0, 8'h00);
    directed(OP_WIPE, 4'd2, 64'd0, 64'd0, 1'b0, 28'd0, 1'b0, 8'h00);
    directed(OP_UNUSED, 4'd0, ID_A, ID_A, 1'b1, SIZE_MAX, 1'b1, 8'hFF);
    directed(OP_SAVE, 4'd7, '1, '1, 1'b1, 28'd0, 1'b1, 8'hFF);
    directed(OP_LOAD, 4'd7, '1, '1, 1'b1, SIZE_MAX, 1'b1, 8'hFF);

    // Largest hole: region too large, then one that just fits
    write_hole_pages(16'hFFFF);
    directed(OP_SAVE, 4'd6, ID_B, ID_A, 1'b0, SIZE_MAX, 1'b0, 8'h00);
    directed(OP_SAVE, 4'd6, ID_B, ID_A, 1'b0, 28'(65534 * PAGE_BYTES), 1'b0, 8'h00);
    directed(OP_WIPE, 4'd6, ID_B, ID_A, 1'b1, 28'd0, 1'b0, 8'h00);

    // Random phases across several hole sizes
    run_phase(16'd1, 90);
    run_phase(16'd2, 90);
    run_phase(16'd5, 90);
    run_phase(16'd12, 90);
    run_phase(16'd40, 90);
    run_phase(16'hFFFF, 90);
    run_phase(16'd160, 90);
    run_phase(16'd3, 90);
    run_phase(16'd24, 90);
    run_phase(16'd255, 90);

    wait_drain();
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/msra_pkg.sv
rtl/msra_slot_cell.sv
rtl/metadata_slot_region_allocator_unit.sv
sim/metadata_slot_region_allocator_unit_test.sv
